// ===== sv/ogrc_pkg.sv =====
// ogrc_pkg: shared types, register codes and direction tables for the occupancy grid ray caster
// no dependencies; imported by ogrc_walker and the top level, not by ogrc_grid_mem

package ogrc_pkg;

  localparam int unsigned DEF_GRID_WIDTH  = 256;
  localparam int unsigned DEF_GRID_HEIGHT = 256;
  localparam int unsigned DEF_MAX_STEPS   = 255;

  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_CELL_SIZE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE = 1'd1;

  localparam logic [9:0]  RST_CELL_SIZE = 10'd50;
  localparam logic [15:0] RST_MAX_RANGE = 16'd5000;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CAST
  } ogrc_state_e;

  typedef struct packed {
    logic        fin;
    logic [15:0] range_mm;
    logic [7:0]  steps;
    logic        hit;
    logic        left_grid;
  } ogrc_res_t;

  // quarter-wave sine, q1.14, 64 steps per quarter turn
  function automatic logic [14:0] sin_rom(input logic [6:0] k);
    logic [14:0] v;
    case (k)
      7'd0:  v = 15'd0;     7'd1:  v = 15'd402;   7'd2:  v = 15'd804;   7'd3:  v = 15'd1205;
      7'd4:  v = 15'd1606;  7'd5:  v = 15'd2006;  7'd6:  v = 15'd2404;  7'd7:  v = 15'd2801;
      7'd8:  v = 15'd3196;  7'd9:  v = 15'd3590;  7'd10: v = 15'd3981;  7'd11: v = 15'd4370;
      7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5520;  7'd15: v = 15'd5897;
      7'd16: v = 15'd6270;  7'd17: v = 15'd6639;  7'd18: v = 15'd7005;  7'd19: v = 15'd7366;
      7'd20: v = 15'd7723;  7'd21: v = 15'd8076;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
      7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9760;  7'd27: v = 15'd10080;
      7'd28: v = 15'd10394; 7'd29: v = 15'd10702; 7'd30: v = 15'd11003; 7'd31: v = 15'd11297;
      7'd32: v = 15'd11585; 7'd33: v = 15'd11866; 7'd34: v = 15'd12140; 7'd35: v = 15'd12406;
      7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13160; 7'd39: v = 15'd13395;
      7'd40: v = 15'd13623; 7'd41: v = 15'd13842; 7'd42: v = 15'd14053; 7'd43: v = 15'd14256;
      7'd44: v = 15'd14449; 7'd45: v = 15'd14635; 7'd46: v = 15'd14811; 7'd47: v = 15'd14978;
      7'd48: v = 15'd15137; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426; 7'd51: v = 15'd15557;
      7'd52: v = 15'd15679; 7'd53: v = 15'd15791; 7'd54: v = 15'd15893; 7'd55: v = 15'd15986;
      7'd56: v = 15'd16069; 7'd57: v = 15'd16143; 7'd58: v = 15'd16207; 7'd59: v = 15'd16261;
      7'd60: v = 15'd16305; 7'd61: v = 15'd16340; 7'd62: v = 15'd16364; 7'd63: v = 15'd16379;
      7'd64: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // sine of a direction in 256ths of a turn, q1.14
  function automatic logic signed [15:0] dir_sine(input logic [7:0] a);
    logic [6:0]         idx;
    logic signed [15:0] v;
    idx = a[6] ? 7'd64 - {1'b0, a[5:0]} : {1'b0, a[5:0]};
    v   = signed'({1'b0, sin_rom(idx)});
    return a[7] ? -v : v;
  endfunction

endpackage

// ===== sv/ogrc_grid_mem.sv =====
// ogrc_grid_mem: one-bit-per-cell occupancy store, one write and one registered read port
// uses nothing from the package

module ogrc_grid_mem #(
  parameter int unsigned AW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [2**AW];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ogrc_walker.sv =====
// ogrc_walker: ray march engine, issues one grid read per cycle while run_i is high and evaluates the previous one
// depends on ogrc_pkg (direction sine, result struct)

module ogrc_walker import ogrc_pkg::*; #(
  parameter int unsigned GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int unsigned GRID_HEIGHT = DEF_GRID_HEIGHT,
  parameter int unsigned MAX_STEPS   = DEF_MAX_STEPS,
  localparam int unsigned XW = $clog2(GRID_WIDTH),
  localparam int unsigned YW = $clog2(GRID_HEIGHT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            launch_i,
  input  logic            run_i,
  input  logic [15:0]     start_x_i,
  input  logic [15:0]     start_y_i,
  input  logic [15:0]     heading_i,
  input  logic [9:0]      cell_size_i,
  input  logic [15:0]     max_range_i,
  input  logic            rd_data_i,
  output logic [XW+YW-1:0] rd_addr_o,
  output ogrc_res_t       res_o
);

  localparam int unsigned SW    = $clog2(MAX_STEPS + 1);
  localparam int unsigned DW    = $clog2(MAX_STEPS * 1024 + 1);
  localparam int unsigned POS_W = $clog2(2**24 + (MAX_STEPS + 2) * 65536) + 1;
  localparam int unsigned CW    = POS_W - 17;

  logic signed [POS_W-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [17:0]      dx_q, dx_d, dy_q, dy_d;
  logic                    ev_valid_q, ev_valid_d;
  logic                    ev_out_q, ev_out_d;
  logic [SW-1:0]           s_q, s_d, s_nxt;
  logic [DW-1:0]           dist_q, dist_d, dist_nxt;
  logic                    left_q, left_d, left_w;
  logic [CW-1:0]           cx, cy;
  logic                    out_now, occ;
  logic signed [15:0]      sin_x, sin_y;
  logic [7:0]              s_sat, s_nxt_sat;

  // cell under the issue position
  assign cx        = pos_x_q[POS_W-2:16];
  assign cy        = pos_y_q[POS_W-2:16];
  assign out_now   = pos_x_q[POS_W-1] || pos_y_q[POS_W-1] ||
                     (32'(cx) >= GRID_WIDTH) || (32'(cy) >= GRID_HEIGHT);
  assign rd_addr_o = {XW'(cx), YW'(cy)};

  assign sin_x = dir_sine(heading_i[15:8] + 8'd64);
  assign sin_y = dir_sine(heading_i[15:8]);

  assign occ       = rd_data_i && !ev_out_q;
  assign left_w    = left_q || ev_out_q;
  assign s_nxt     = s_q + SW'(1);
  assign dist_nxt  = dist_q + DW'(cell_size_i);
  assign s_sat     = (32'(s_q) > 255) ? 8'hFF : 8'(s_q);
  assign s_nxt_sat = (32'(s_nxt) > 255) ? 8'hFF : 8'(s_nxt);

  always_comb begin
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    ev_valid_d = ev_valid_q;
    ev_out_d   = ev_out_q;
    s_d        = s_q;
    dist_d     = dist_q;
    left_d     = left_q;
    res_o      = '0;
    res_o.left_grid = left_w;
    if (launch_i) begin
      pos_x_d    = signed'(POS_W'({start_x_i, 8'h00}));
      pos_y_d    = signed'(POS_W'({start_y_i, 8'h00}));
      dx_d       = signed'({sin_x, 2'b00});
      dy_d       = signed'({sin_y, 2'b00});
      ev_valid_d = 1'b0;
      s_d        = '0;
      dist_d     = '0;
      left_d     = 1'b0;
    end else if (run_i) begin
      pos_x_d    = pos_x_q + POS_W'(dx_q);
      pos_y_d    = pos_y_q + POS_W'(dy_q);
      ev_out_d   = out_now;
      ev_valid_d = 1'b1;
      if (ev_valid_q) begin
        left_d = left_w;
        if (occ) begin
          res_o.fin      = 1'b1;
          res_o.hit      = 1'b1;
          res_o.range_mm = 16'(dist_q);
          res_o.steps    = s_sat;
        end else if (s_q >= SW'(MAX_STEPS)) begin
          res_o.fin      = 1'b1;
          res_o.range_mm = max_range_i;
          res_o.steps    = s_sat;
        end else begin
          s_d    = s_nxt;
          dist_d = dist_nxt;
          if (32'(dist_nxt) > 32'(max_range_i)) begin
            res_o.fin      = 1'b1;
            res_o.range_mm = max_range_i;
            res_o.steps    = s_nxt_sat;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else begin
      ev_valid_q <= ev_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q  <= pos_x_d;
    pos_y_q  <= pos_y_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    ev_out_q <= ev_out_d;
    s_q      <= s_d;
    dist_q   <= dist_d;
    left_q   <= left_d;
  end

  a_fresh_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(run_i) |-> !ev_valid_q)
    else $error("stale read evaluated at start of cast");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_i && ev_valid_q |-> 32'(s_q) <= MAX_STEPS)
    else $error("step counter beyond limit");

endmodule

// ===== sv/occupancy_grid_ray_cast.sv =====
// occupancy_grid_ray_cast: top level, config registers, grid clear pass, request control
// depends on ogrc_pkg, ogrc_grid_mem and ogrc_walker
//
// a request is taken at a rising edge with start high and busy low; kind_i selects a cell
// write (cell_x_i, cell_y_i, occupied_i) or a ray cast (start_x_i, start_y_i, heading_i)
// each request gives exactly one result on range_mm_o, step_count_o, hit_o, left_grid_o,
// shown for one cycle with done_o high; the receiver cannot stall, results are not held
// a write shows its all-zero result in the cycle after the request and leaves busy low,
// so writes can be taken every cycle
// a cast shows its result on a hit, at the step limit, or when the range runs out; the walker
// does one grid read per cycle on the single read port, and busy stays high while it runs
// busy is low in the cycle done_o is high, so the next request can be taken there
// after reset the grid is swept to free, one cell a cycle, over all GRID_WIDTH * GRID_HEIGHT
// cells (both rounded up to powers of two); busy stays high until the sweep ends
// config writes (cfg_we_i, cfg_addr_i, cfg_wdata_i) take effect at once; index 0 is the
// cell size in mm, index 1 the maximum range in mm; write them only while the block is idle

module occupancy_grid_ray_cast import ogrc_pkg::*; #(
  parameter int unsigned GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int unsigned GRID_HEIGHT = DEF_GRID_HEIGHT,
  parameter int unsigned MAX_STEPS   = DEF_MAX_STEPS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_addr_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 start,
  output logic                 busy,
  input  logic                 kind_i,
  input  logic [7:0]           cell_x_i,
  input  logic [7:0]           cell_y_i,
  input  logic                 occupied_i,
  input  logic [15:0]          start_x_i,
  input  logic [15:0]          start_y_i,
  input  logic [15:0]          heading_i,
  output logic                 done_o,
  output logic [15:0]          range_mm_o,
  output logic [7:0]           step_count_o,
  output logic                 hit_o,
  output logic                 left_grid_o
);

  localparam int unsigned XW = $clog2(GRID_WIDTH);
  localparam int unsigned YW = $clog2(GRID_HEIGHT);
  localparam int unsigned AW = XW + YW;

  ogrc_state_e   st_q, st_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [9:0]    cell_size_q;
  logic [15:0]   max_range_q;
  logic          done_q, done_d;
  logic [15:0]   range_q, range_d;
  logic [7:0]    steps_q, steps_d;
  logic          hit_q, hit_d;
  logic          left_q, left_d;

  logic          mem_we, mem_wdata, mem_rdata;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic          launch, run, cell_ok;
  ogrc_res_t     res;

  assign cell_ok = (32'(cell_x_i) < GRID_WIDTH) && (32'(cell_y_i) < GRID_HEIGHT);
  assign run     = (st_q == ST_CAST);
  assign busy    = (st_q != ST_IDLE);

  always_comb begin
    st_d      = st_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 1'b0;
    launch    = 1'b0;
    done_d    = 1'b0;
    range_d   = range_q;
    steps_d   = steps_q;
    hit_d     = hit_q;
    left_d    = left_q;
    case (st_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == '1) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (kind_i == KIND_CAST) begin
            launch = 1'b1;
            st_d   = ST_CAST;
          end else begin
            mem_we    = cell_ok;
            mem_waddr = {XW'(cell_x_i), YW'(cell_y_i)};
            mem_wdata = occupied_i;
            done_d    = 1'b1;
            range_d   = '0;
            steps_d   = '0;
            hit_d     = 1'b0;
            left_d    = 1'b0;
          end
        end
      end
      ST_CAST: begin
        if (res.fin) begin
          st_d    = ST_IDLE;
          done_d  = 1'b1;
          range_d = res.range_mm;
          steps_d = res.steps;
          hit_d   = res.hit;
          left_d  = res.left_grid;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_CLEAR;
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      clr_q  <= clr_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= RST_CELL_SIZE;
      max_range_q <= RST_MAX_RANGE;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_CELL_SIZE: cell_size_q <= cfg_wdata_i[9:0];
        REG_MAX_RANGE: max_range_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    range_q <= range_d;
    steps_q <= steps_d;
    hit_q   <= hit_d;
    left_q  <= left_d;
  end

  ogrc_grid_mem #(
    .AW (AW)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ogrc_walker #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .MAX_STEPS   (MAX_STEPS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .launch_i    (launch),
    .run_i       (run),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .heading_i   (heading_i),
    .cell_size_i (cell_size_q),
    .max_range_i (max_range_q),
    .rd_data_i   (mem_rdata),
    .rd_addr_o   (mem_raddr),
    .res_o       (res)
  );

  assign done_o       = done_q;
  assign range_mm_o   = range_q;
  assign step_count_o = steps_q;
  assign hit_o        = hit_q;
  assign left_grid_o  = left_q;

  a_cast_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(st_q == ST_CAST) && st_q == ST_IDLE |-> done_q)
    else $error("cast ended without a result strobe");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && kind_i == KIND_WRITE |=> done_q && !hit_q && !left_q && range_q == '0)
    else $error("write request without its zero result");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_CLEAR |-> !done_q)
    else $error("result strobe during grid clear");

endmodule
